// ===== hdl/i2cm_pkg.sv =====
// Package for the I2C master transaction engine: phase and sequence codes.
// No dependencies.
`default_nettype none
package i2cm_pkg;
    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH,
        PH_ACK_LOW, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
        PH_RSP_A, PH_RSP_B, PH_SP_A, PH_SP_B
    } t_phase;

    typedef enum logic [2:0] {
        OP_END, OP_START, OP_TXW, OP_TXR, OP_TXREG, OP_TXDAT, OP_RX, OP_STOP
    } t_op;

    localparam int SEQ_LEN = 9;
    localparam int SEQ_W   = 4;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_WR   = 2'd1;
    localparam logic [1:0] FN_RREG = 2'd2;
    localparam logic [1:0] FN_RDIR = 2'd3;

    localparam logic CFG_UNIT = 1'b0;
    localparam logic CFG_ACKW = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [7:0] rd_len;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       done_res;
        logic       status;
    } t_out;

    // command sequence table
    function automatic t_op seq_op(input logic [1:0] fn, input logic [SEQ_W-1:0] idx);
        t_op op;
        op = OP_END;
        case (fn)
            FN_WR: begin
                case (idx)
                    4'd0: op = OP_START;
                    4'd1: op = OP_TXW;
                    4'd2: op = OP_TXREG;
                    4'd3: op = OP_TXDAT;
                    4'd4: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            FN_RREG: begin
                case (idx)
                    4'd0: op = OP_START;
                    4'd1: op = OP_TXW;
                    4'd2: op = OP_TXREG;
                    4'd3: op = OP_STOP;
                    4'd4: op = OP_START;
                    4'd5: op = OP_TXR;
                    4'd6: op = OP_RX;
                    4'd7: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            FN_RDIR: begin
                case (idx)
                    4'd0: op = OP_START;
                    4'd1: op = OP_TXR;
                    4'd2: op = OP_RX;
                    4'd3: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/i2cm_if.sv =====
// Valid/ready channel interface carrying one item.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface i2cm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/i2c_master_transaction_engine_core.sv =====
// Top level of the I2C master transaction engine.
// Depends on i2cm_pkg, i2cm_if and i2cm_units.
//
// Usage: each input item on s_in is one bus tick carrying the sampled SDA
// level and, while idle, an optional command (func nonzero). Each accepted
// item yields exactly one result item on m_out with the pin levels, busy,
// received byte strobe and done/status. The engine state advances once per
// accepted item, all in one pass of logic into the state registers and the
// result register, valid the cycle after; one item is taken every cycle.
// The result register is the only buffer: s_in is ready whenever it is empty
// or being taken, so a stalled receiver holds the engine after one item.
// Configuration (unit_ticks index 0, ack_window index 1) via i_cfg_*.
// Reset brings the bus idle with SCL, SDA high and drive enabled,
// unit_ticks 20, ack_window 250.
`default_nettype none
module i2c_master_transaction_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    i2cm_if.sink             s_in,
    i2cm_if.source           m_out
);
    logic [15:0] r_unit;
    logic [7:0]  r_ackw;
    i2cm_pkg::t_phase r_phase, n_phase;
    logic [18:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift, r_bcnt, n_bcnt;
    logic [1:0]  r_op, n_op;
    logic [6:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg, r_dat, n_dat, r_len, n_len;
    logic        r_scl, n_scl, r_sda, n_sda, r_oe, n_oe, r_abort, n_abort;
    logic [3:0]  r_seq, n_seq;
    logic        r_ovalid;
    i2cm_pkg::t_out r_out, n_out;
    logic        take;
    logic [15:0] u1;
    logic [17:0] u3, u4;
    logic [18:0] u5;

    i2cm_units u_units (.i_unit(r_unit), .o_u1(u1), .o_u3(u3), .o_u4(u4), .o_u5(u5));

    assign s_in.ready  = !r_ovalid || m_out.ready;
    assign take        = s_in.valid && s_in.ready;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= 16'd20;
            r_ackw <= 8'd250;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == i2cm_pkg::CFG_UNIT) r_unit <= i_cfg_data;
            else r_ackw <= i_cfg_data[7:0];
        end
    end

    // one tick of the engine
    always_comb begin
        i2cm_pkg::t_op op0, op1, op;
        logic [3:0] sq;
        logic valid, last, fin, do_begin, tx;
        logic [7:0] txb;
        logic [3:0] bi;
        n_phase = r_phase; n_tick = r_tick; n_bit = r_bit; n_shift = r_shift;
        n_bcnt = r_bcnt; n_op = r_op; n_dev = r_dev; n_reg = r_reg; n_dat = r_dat;
        n_len = r_len; n_scl = r_scl; n_sda = r_sda; n_oe = r_oe;
        n_abort = r_abort; n_seq = r_seq;
        valid = 1'b0; last = 1'b0; fin = 1'b0; do_begin = 1'b0;
        tx = 1'b0; txb = 8'd0; op = i2cm_pkg::OP_END; sq = 4'd0;
        op0 = i2cm_pkg::OP_END; op1 = i2cm_pkg::OP_END;
        bi = r_bit + 4'd1;
        if (r_phase == i2cm_pkg::PH_IDLE) begin
            if (s_in.data.func != i2cm_pkg::FN_TICK) begin
                n_op = s_in.data.func; n_dev = s_in.data.dev_addr;
                n_reg = s_in.data.reg_addr; n_dat = s_in.data.wr_data;
                n_len = s_in.data.rd_len; n_seq = 4'd0; n_bcnt = 8'd0;
                n_abort = 1'b0; do_begin = 1'b1;
            end
        end else if (r_phase == i2cm_pkg::PH_ACK_POLL && !s_in.data.sda_in) begin
            n_seq = r_seq + 4'd1; do_begin = 1'b1;
        end else if (r_tick <= 19'd1) begin
            unique case (r_phase)
                i2cm_pkg::PH_ST_A: begin
                    n_phase = i2cm_pkg::PH_ST_B; n_tick = u5;
                    n_scl = 1'b1; n_sda = 1'b0; n_oe = 1'b1;
                end
                i2cm_pkg::PH_ST_B: begin
                    n_phase = i2cm_pkg::PH_ST_C; n_tick = u5;
                    n_scl = 1'b0; n_sda = 1'b0; n_oe = 1'b1;
                end
                i2cm_pkg::PH_ST_C: begin n_seq = r_seq + 4'd1; do_begin = 1'b1; end
                i2cm_pkg::PH_TX_LOW: begin
                    n_phase = i2cm_pkg::PH_TX_DATA; n_tick = {3'b000, u1};
                    n_scl = 1'b0; n_sda = r_shift[7]; n_oe = 1'b1;
                end
                i2cm_pkg::PH_TX_DATA: begin
                    n_phase = i2cm_pkg::PH_TX_HIGH; n_tick = {3'b000, u1};
                    n_scl = 1'b1; n_oe = 1'b1;
                end
                i2cm_pkg::PH_TX_HIGH: begin
                    n_shift = {r_shift[6:0], 1'b0}; n_bit = bi;
                    n_scl = 1'b0; n_oe = 1'b1;
                    if (bi >= 4'd8) begin
                        n_phase = i2cm_pkg::PH_ACK_LOW; n_tick = {1'b0, u3};
                    end else begin
                        n_phase = i2cm_pkg::PH_TX_LOW; n_tick = {3'b000, u1};
                    end
                end
                i2cm_pkg::PH_ACK_LOW: begin
                    n_phase = i2cm_pkg::PH_ACK_REL; n_tick = {1'b0, u3};
                    n_scl = 1'b0; n_oe = 1'b0;
                end
                i2cm_pkg::PH_ACK_REL: begin
                    n_phase = i2cm_pkg::PH_ACK_HIGH; n_tick = {3'b000, u1};
                    n_scl = 1'b1; n_oe = 1'b0;
                end
                i2cm_pkg::PH_ACK_HIGH: begin
                    n_phase = i2cm_pkg::PH_ACK_POLL;
                    n_tick = (r_ackw == 8'd0) ? 19'd1 : {11'd0, r_ackw};
                    n_scl = 1'b1; n_oe = 1'b0;
                end
                i2cm_pkg::PH_ACK_POLL: begin
                    n_abort = 1'b1; n_phase = i2cm_pkg::PH_SP_A; n_tick = {1'b0, u4};
                    n_scl = 1'b0; n_sda = 1'b0; n_oe = 1'b1;
                end
                i2cm_pkg::PH_RX_LOW: begin
                    n_phase = i2cm_pkg::PH_RX_HIGH; n_tick = {3'b000, u1};
                    n_scl = 1'b1; n_oe = 1'b0;
                end
                i2cm_pkg::PH_RX_HIGH: begin
                    n_shift = {r_shift[6:0], s_in.data.sda_in}; n_bit = bi;
                    n_tick = {3'b000, u1}; n_scl = 1'b0;
                    if (bi < 4'd8) begin
                        n_phase = i2cm_pkg::PH_RX_LOW; n_oe = 1'b0;
                    end else begin
                        n_bcnt = r_bcnt + 8'd1; valid = 1'b1;
                        last = (r_bcnt + 8'd1) >= r_len;
                        n_phase = i2cm_pkg::PH_RSP_A; n_sda = last; n_oe = 1'b1;
                    end
                end
                i2cm_pkg::PH_RSP_A: begin
                    n_phase = i2cm_pkg::PH_RSP_B; n_tick = {3'b000, u1};
                    n_scl = 1'b1; n_oe = 1'b1;
                end
                i2cm_pkg::PH_RSP_B: do_begin = 1'b1;
                i2cm_pkg::PH_SP_A: begin
                    n_phase = i2cm_pkg::PH_SP_B; n_tick = {1'b0, u4};
                    n_scl = 1'b1; n_sda = 1'b1; n_oe = 1'b1;
                end
                i2cm_pkg::PH_SP_B: begin
                    if (r_abort) fin = 1'b1;
                    else begin n_seq = r_seq + 4'd1; do_begin = 1'b1; end
                end
                default: fin = 1'b1;
            endcase
        end else begin
            n_tick = r_tick - 19'd1;
        end

        // start the next sequence step; an exhausted read skips one step
        if (do_begin) begin
            sq = n_seq;
            op0 = (sq < 4'(i2cm_pkg::SEQ_LEN)) ? i2cm_pkg::seq_op(n_op, sq)
                                               : i2cm_pkg::OP_END;
            op1 = (sq + 4'd1 < 4'(i2cm_pkg::SEQ_LEN)) ? i2cm_pkg::seq_op(n_op, sq + 4'd1)
                                                      : i2cm_pkg::OP_END;
            op = op0;
            if (op0 == i2cm_pkg::OP_RX && !(n_bcnt < n_len)) begin
                op = op1; n_seq = sq + 4'd1;
            end
            case (op)
                i2cm_pkg::OP_START: begin
                    n_phase = i2cm_pkg::PH_ST_A; n_tick = u5;
                    n_scl = 1'b1; n_sda = 1'b1; n_oe = 1'b1;
                end
                i2cm_pkg::OP_TXW:   begin tx = 1'b1; txb = {n_dev, 1'b0}; end
                i2cm_pkg::OP_TXR:   begin tx = 1'b1; txb = {n_dev, 1'b1}; end
                i2cm_pkg::OP_TXREG: begin tx = 1'b1; txb = n_reg; end
                i2cm_pkg::OP_TXDAT: begin tx = 1'b1; txb = n_dat; end
                i2cm_pkg::OP_RX: begin
                    n_shift = 8'd0; n_bit = 4'd0; n_phase = i2cm_pkg::PH_RX_LOW;
                    n_tick = {3'b000, u1}; n_scl = 1'b0; n_oe = 1'b0;
                end
                i2cm_pkg::OP_STOP: begin
                    n_phase = i2cm_pkg::PH_SP_A; n_tick = {1'b0, u4};
                    n_scl = 1'b0; n_sda = 1'b0; n_oe = 1'b1;
                end
                default: fin = 1'b1;
            endcase
            if (tx) begin
                n_shift = txb; n_bit = 4'd0; n_phase = i2cm_pkg::PH_TX_LOW;
                n_tick = {3'b000, u1}; n_scl = 1'b0; n_oe = 1'b1;
            end
        end
        if (fin) begin
            n_phase = i2cm_pkg::PH_IDLE; n_tick = 19'd0;
            n_scl = 1'b1; n_sda = 1'b1; n_oe = 1'b1;
        end

        n_out.scl_level  = n_scl;
        n_out.sda_level  = n_oe & n_sda;
        n_out.sda_enable = n_oe;
        n_out.busy_res   = n_phase != i2cm_pkg::PH_IDLE;
        n_out.rd_byte    = valid ? n_shift : 8'd0;
        n_out.rd_valid   = valid;
        n_out.rd_last    = valid & last;
        n_out.done_res   = fin;
        n_out.status     = fin & n_abort;
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cm_pkg::PH_IDLE; r_tick <= 19'd0; r_bit <= 4'd0;
            r_shift <= 8'd0; r_bcnt <= 8'd0; r_op <= 2'd0; r_dev <= 7'd0;
            r_reg <= 8'd0; r_dat <= 8'd0; r_len <= 8'd0; r_scl <= 1'b1;
            r_sda <= 1'b1; r_oe <= 1'b1; r_abort <= 1'b0; r_seq <= 4'd0;
        end else if (take) begin
            r_phase <= n_phase; r_tick <= n_tick; r_bit <= n_bit;
            r_shift <= n_shift; r_bcnt <= n_bcnt; r_op <= n_op; r_dev <= n_dev;
            r_reg <= n_reg; r_dat <= n_dat; r_len <= n_len; r_scl <= n_scl;
            r_sda <= n_sda; r_oe <= n_oe; r_abort <= n_abort; r_seq <= n_seq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (take) r_ovalid <= 1'b1;
        else if (m_out.ready) r_ovalid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end
endmodule
`default_nettype wire

// ===== hdl/i2cm_units.sv =====
// Delay unit multiples: n * unit_ticks for n = 1, 3, 4, 5, zero treated as one.
// Depends on nothing.
`default_nettype none
module i2cm_units (
    input  wire logic [15:0] i_unit,
    output logic [15:0]      o_u1,
    output logic [17:0]      o_u3,
    output logic [17:0]      o_u4,
    output logic [18:0]      o_u5
);
    logic [15:0] u;
    assign u    = (i_unit == 16'd0) ? 16'd1 : i_unit;
    assign o_u1 = u;
    assign o_u3 = {2'b00, u} + {1'b0, u, 1'b0};
    assign o_u4 = {u, 2'b00};
    assign o_u5 = {3'b000, u} + {1'b0, u, 2'b00};
endmodule
`default_nettype wire

// ===== hdl/i2cm_checker.sv =====
// Port-level checker for the I2C master engine, bound to the top level.
// Depends on i2cm_pkg and i2cm_if.
`default_nettype none
module i2cm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire i2cm_pkg::t_out out_data
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready) else $error("not ready with empty output");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> out_valid) else $error("accepted item gave no result");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.rd_last |-> out_data.rd_valid)
        else $error("last without valid byte");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.status |-> out_data.done_res && !out_data.busy_res)
        else $error("status without done");
endmodule

bind i2c_master_transaction_engine_core i2cm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the I2C master transaction engine core.
// Depends on i2cm_pkg and i2cm_if; models a bus device on sda_in and predicts every pin item.
`timescale 1ns / 100ps
module testbench;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int TOTAL_ITEMS  = 1050;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = i2cm_pkg::CFG_UNIT;
    logic [15:0] cfg_data = '0;

    i2cm_if #(.T(i2cm_pkg::t_in))  in_ch ();
    i2cm_if #(.T(i2cm_pkg::t_out)) out_ch ();

    i2c_master_transaction_engine_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // bus model state
    i2cm_pkg::t_phase ph = i2cm_pkg::PH_IDLE;
    logic [19:0] tcnt = '0;
    logic [3:0]  bits = '0;
    logic [7:0]  shf = '0;
    logic [7:0]  nbytes = '0;
    logic [1:0]  s_op = '0;
    logic [6:0]  s_dev = '0;
    logic [7:0]  s_reg = '0;
    logic [7:0]  s_dat = '0;
    logic [7:0]  s_len = '0;
    logic        scl_q = 1'b1, sda_q = 1'b1, oe_q = 1'b1;
    int          seq_i = 0;
    logic        abrt = 1'b0, fin = 1'b0;
    logic [15:0] unit_cfg = 16'd20;
    logic [7:0]  ackw_cfg = 8'd250;

    i2cm_pkg::t_op cmd_seq [4][9] = '{
        '{i2cm_pkg::OP_END, i2cm_pkg::OP_END, i2cm_pkg::OP_END,
          i2cm_pkg::OP_END, i2cm_pkg::OP_END, i2cm_pkg::OP_END,
          i2cm_pkg::OP_END, i2cm_pkg::OP_END, i2cm_pkg::OP_END},
        '{i2cm_pkg::OP_START, i2cm_pkg::OP_TXW, i2cm_pkg::OP_TXREG,
          i2cm_pkg::OP_TXDAT, i2cm_pkg::OP_STOP, i2cm_pkg::OP_END,
          i2cm_pkg::OP_END, i2cm_pkg::OP_END, i2cm_pkg::OP_END},
        '{i2cm_pkg::OP_START, i2cm_pkg::OP_TXW, i2cm_pkg::OP_TXREG,
          i2cm_pkg::OP_STOP, i2cm_pkg::OP_START, i2cm_pkg::OP_TXR,
          i2cm_pkg::OP_RX, i2cm_pkg::OP_STOP, i2cm_pkg::OP_END},
        '{i2cm_pkg::OP_START, i2cm_pkg::OP_TXR, i2cm_pkg::OP_RX,
          i2cm_pkg::OP_STOP, i2cm_pkg::OP_END, i2cm_pkg::OP_END,
          i2cm_pkg::OP_END, i2cm_pkg::OP_END, i2cm_pkg::OP_END}
    };

    i2cm_pkg::t_out bus_levels_q[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   items_sent = 0;
    int   nack_pct = 0;
    bit   no_gap = 0;

    function automatic logic [19:0] units(int n);
        return 20'(n * ((unit_cfg == 0) ? 20'd1 : 20'(unit_cfg)));
    endfunction

    function automatic void go(i2cm_pkg::t_phase p, logic [19:0] t, logic scl, logic sda,
                               logic oe);
        ph = p;
        tcnt = (t == 0) ? 20'd1 : t;
        scl_q = scl;
        sda_q = sda;
        oe_q = oe;
    endfunction

    function automatic void load_byte(logic [7:0] b);
        shf = b;
        bits = '0;
        go(i2cm_pkg::PH_TX_LOW, units(1), 1'b0, sda_q, 1'b1);
    endfunction

    function automatic void release_bus();
        ph = i2cm_pkg::PH_IDLE;
        tcnt = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        oe_q = 1'b1;
        fin = 1'b1;
    endfunction

    // walk the command sequence to the next bus action
    function automatic void next_op();
        i2cm_pkg::t_op op;
        while (1) begin
            op = (seq_i < 9) ? cmd_seq[s_op][seq_i] : i2cm_pkg::OP_END;
            case (op)
                i2cm_pkg::OP_START: begin
                    go(i2cm_pkg::PH_ST_A, units(5), 1'b1, 1'b1, 1'b1);
                    return;
                end
                i2cm_pkg::OP_TXW: begin
                    load_byte({s_dev, 1'b0});
                    return;
                end
                i2cm_pkg::OP_TXR: begin
                    load_byte({s_dev, 1'b1});
                    return;
                end
                i2cm_pkg::OP_TXREG: begin
                    load_byte(s_reg);
                    return;
                end
                i2cm_pkg::OP_TXDAT: begin
                    load_byte(s_dat);
                    return;
                end
                i2cm_pkg::OP_RX: begin
                    if (nbytes < s_len) begin
                        shf = '0;
                        bits = '0;
                        go(i2cm_pkg::PH_RX_LOW, units(1), 1'b0, sda_q, 1'b0);
                        return;
                    end
                    seq_i++;
                end
                i2cm_pkg::OP_STOP: begin
                    go(i2cm_pkg::PH_SP_A, units(4), 1'b0, 1'b0, 1'b1);
                    return;
                end
                default: begin
                    release_bus();
                    return;
                end
            endcase
        end
    endfunction

    function automatic void phase_done(input logic sd, output logic v, output logic l);
        v = 1'b0;
        l = 1'b0;
        case (ph)
            i2cm_pkg::PH_ST_A: go(i2cm_pkg::PH_ST_B, units(5), 1'b1, 1'b0, 1'b1);
            i2cm_pkg::PH_ST_B: go(i2cm_pkg::PH_ST_C, units(5), 1'b0, 1'b0, 1'b1);
            i2cm_pkg::PH_ST_C: begin
                seq_i++;
                next_op();
            end
            i2cm_pkg::PH_TX_LOW:
                go(i2cm_pkg::PH_TX_DATA, units(1), 1'b0, shf[7], 1'b1);
            i2cm_pkg::PH_TX_DATA:
                go(i2cm_pkg::PH_TX_HIGH, units(1), 1'b1, sda_q, 1'b1);
            i2cm_pkg::PH_TX_HIGH: begin
                shf = shf << 1;
                bits++;
                if (bits >= 8) go(i2cm_pkg::PH_ACK_LOW, units(3), 1'b0, sda_q, 1'b1);
                else go(i2cm_pkg::PH_TX_LOW, units(1), 1'b0, sda_q, 1'b1);
            end
            i2cm_pkg::PH_ACK_LOW:
                go(i2cm_pkg::PH_ACK_REL, units(3), 1'b0, sda_q, 1'b0);
            i2cm_pkg::PH_ACK_REL:
                go(i2cm_pkg::PH_ACK_HIGH, units(1), 1'b1, sda_q, 1'b0);
            i2cm_pkg::PH_ACK_HIGH:
                go(i2cm_pkg::PH_ACK_POLL, 20'(ackw_cfg), 1'b1, sda_q, 1'b0);
            i2cm_pkg::PH_ACK_POLL: begin
                // poll window ran out: no acknowledge
                abrt = 1'b1;
                go(i2cm_pkg::PH_SP_A, units(4), 1'b0, 1'b0, 1'b1);
            end
            i2cm_pkg::PH_RX_LOW:
                go(i2cm_pkg::PH_RX_HIGH, units(1), 1'b1, sda_q, 1'b0);
            i2cm_pkg::PH_RX_HIGH: begin
                shf = {shf[6:0], sd};
                bits++;
                if (bits < 8) begin
                    go(i2cm_pkg::PH_RX_LOW, units(1), 1'b0, sda_q, 1'b0);
                end else begin
                    nbytes++;
                    v = 1'b1;
                    l = (nbytes >= s_len);
                    go(i2cm_pkg::PH_RSP_A, units(1), 1'b0, l, 1'b1);
                end
            end
            i2cm_pkg::PH_RSP_A:
                go(i2cm_pkg::PH_RSP_B, units(1), 1'b1, sda_q, 1'b1);
            i2cm_pkg::PH_RSP_B: next_op();
            i2cm_pkg::PH_SP_A:
                go(i2cm_pkg::PH_SP_B, units(4), 1'b1, 1'b1, 1'b1);
            i2cm_pkg::PH_SP_B: begin
                if (abrt) begin
                    release_bus();
                end else begin
                    seq_i++;
                    next_op();
                end
            end
            default: release_bus();
        endcase
    endfunction

    // advance the bus model by one tick and return the expected pin item
    function automatic i2cm_pkg::t_out bus_step(i2cm_pkg::t_in it);
        i2cm_pkg::t_out r;
        logic v, l;
        v = 1'b0;
        l = 1'b0;
        fin = 1'b0;
        if (ph == i2cm_pkg::PH_IDLE) begin
            if (it.func != i2cm_pkg::FN_TICK) begin
                s_op = it.func;
                s_dev = it.dev_addr;
                s_reg = it.reg_addr;
                s_dat = it.wr_data;
                s_len = it.rd_len;
                seq_i = 0;
                nbytes = '0;
                abrt = 1'b0;
                next_op();
            end
        end else if (ph == i2cm_pkg::PH_ACK_POLL && it.sda_in == 1'b0) begin
            seq_i++;
            next_op();
        end else begin
            if (tcnt != 0) tcnt--;
            if (tcnt == 0) phase_done(it.sda_in, v, l);
        end
        r.scl_level = scl_q;
        r.sda_level = oe_q ? sda_q : 1'b0;
        r.sda_enable = oe_q;
        r.busy_res = (ph != i2cm_pkg::PH_IDLE);
        r.rd_byte = v ? shf : 8'd0;
        r.rd_valid = v;
        r.rd_last = v && l;
        r.done_res = fin;
        r.status = fin && abrt;
        return r;
    endfunction

    // device side: acknowledge (sometimes late or never), random read data
    function automatic logic device_sda();
        if (ph == i2cm_pkg::PH_ACK_POLL) begin
            if ($urandom_range(99) < nack_pct) return 1'b1;
            return ($urandom_range(3) == 0);
        end
        return 1'($urandom_range(1));
    endfunction

    function automatic i2cm_pkg::t_in bus_tick();
        i2cm_pkg::t_in it;
        it.func = 2'($urandom_range(3));
        it.dev_addr = 7'($urandom);
        it.reg_addr = 8'($urandom);
        it.wr_data = 8'($urandom);
        it.rd_len = 8'($urandom);
        it.sda_in = device_sda();
        if (ph == i2cm_pkg::PH_IDLE) it.func = i2cm_pkg::FN_TICK;
        return it;
    endfunction

    // send one item, predict on acceptance, then maybe leave a gap
    task automatic send_item(i2cm_pkg::t_in it);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        bus_levels_q.push_back(bus_step(it));
        items_sent++;
        g = 0;
        if (!no_gap) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: g = $urandom_range(1, 3);
                6:       g = $urandom_range(8, 30);
                default: g = 0;
            endcase
        end
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic run_until_idle();
        while (ph != i2cm_pkg::PH_IDLE) send_item(bus_tick());
    endtask

    task automatic run_cmd(logic [1:0] fn, logic [6:0] dev, logic [7:0] ra,
                           logic [7:0] wd, logic [7:0] len);
        i2cm_pkg::t_in it;
        it.func = fn;
        it.dev_addr = dev;
        it.reg_addr = ra;
        it.wr_data = wd;
        it.rd_len = len;
        it.sda_in = 1'($urandom_range(1));
        send_item(it);
        run_until_idle();
    endtask

    // register write, only with the engine idle and all items drained
    task automatic write_reg(logic idx, logic [15:0] val);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bus_levels_q.size() != 0) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == i2cm_pkg::CFG_UNIT) unit_cfg = val;
        else ackw_cfg = val[7:0];
    endtask

    task automatic test_idle_ticks();
        i2cm_pkg::t_in it;
        it = '0;
        for (int k = 0; k < 4; k++) begin
            it.sda_in = k[0];
            send_item(it);
        end
    endtask

    task automatic test_write();
        write_reg(i2cm_pkg::CFG_UNIT, 16'd1);
        nack_pct = 0;
        run_cmd(i2cm_pkg::FN_WR, 7'h7f, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic test_reg_read();
        run_cmd(i2cm_pkg::FN_RREG, 7'h2a, 8'h5a, 8'h00, 8'd2);
    endtask

    task automatic test_direct_read();
        run_cmd(i2cm_pkg::FN_RDIR, 7'h3c, 8'h00, 8'h00, 8'd0);
        run_cmd(i2cm_pkg::FN_RDIR, 7'h43, 8'h00, 8'h00, 8'd1);
    endtask

    task automatic test_nack();
        nack_pct = 100;
        write_reg(i2cm_pkg::CFG_ACKW, 16'd1);
        run_cmd(i2cm_pkg::FN_WR, 7'h12, 8'h34, 8'h56, 8'd0);
        write_reg(i2cm_pkg::CFG_ACKW, 16'd40);
        run_cmd(i2cm_pkg::FN_RDIR, 7'h21, 8'h00, 8'h00, 8'd4);
        // zero window and zero unit both act as one
        write_reg(i2cm_pkg::CFG_ACKW, 16'hff00);
        write_reg(i2cm_pkg::CFG_UNIT, 16'd0);
        run_cmd(i2cm_pkg::FN_RREG, 7'h0f, 8'hf0, 8'h00, 8'd2);
        nack_pct = 0;
        write_reg(i2cm_pkg::CFG_ACKW, 16'd250);
    endtask

    task automatic test_unit_extremes();
        i2cm_pkg::t_in it;
        write_reg(i2cm_pkg::CFG_UNIT, 16'hffff);
        it = '0;
        send_item(it);
        send_item(it);
        write_reg(i2cm_pkg::CFG_UNIT, 16'd2);
        run_cmd(i2cm_pkg::FN_RDIR, 7'h5a, 8'h00, 8'h00, 8'd1);
    endtask

    // random transactions with random content, config changed between them
    task automatic test_random();
        i2cm_pkg::t_in it;
        int r;
        while (items_sent < TOTAL_ITEMS) begin
            if (ph == i2cm_pkg::PH_IDLE && $urandom_range(7) == 0) begin
                case ($urandom_range(4))
                    0: write_reg(i2cm_pkg::CFG_UNIT, 16'd0);
                    1, 2: write_reg(i2cm_pkg::CFG_UNIT, 16'd1);
                    3: write_reg(i2cm_pkg::CFG_UNIT, 16'd2);
                    default: write_reg(i2cm_pkg::CFG_UNIT, 16'($urandom_range(3, 4)));
                endcase
                case ($urandom_range(3))
                    0: write_reg(i2cm_pkg::CFG_ACKW, 16'($urandom_range(0, 1)));
                    1: write_reg(i2cm_pkg::CFG_ACKW, 16'd255);
                    default: write_reg(i2cm_pkg::CFG_ACKW, 16'($urandom_range(2, 12)));
                endcase
            end
            it = bus_tick();
            if (ph == i2cm_pkg::PH_IDLE) begin
                nack_pct = ($urandom_range(4) == 0) ? 30 : 0;
                no_gap = ($urandom_range(3) == 0);
                if ($urandom_range(9) < 7) it.func = 2'($urandom_range(1, 3));
                r = $urandom_range(99);
                if (r < 85) it.rd_len = 8'($urandom_range(0, 3));
                else if (r < 98) it.rd_len = 8'($urandom_range(4, 16));
            end
            send_item(it);
        end
        no_gap = 0;
    endtask

    // receiver stalls: mostly ready, short and long stalls
    int rdy_hold = 0;
    always @(posedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: begin
                    out_ch.ready <= 1'b0;
                    rdy_hold = $urandom_range(1, 3);
                end
                7: begin
                    out_ch.ready <= 1'b0;
                    rdy_hold = $urandom_range(8, 30);
                end
                default: begin
                    out_ch.ready <= 1'b1;
                    rdy_hold = $urandom_range(1, 40);
                end
            endcase
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        i2cm_pkg::t_out got, exp_o;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (bus_levels_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: got %p", got);
            end else begin
                exp_o = bus_levels_q.pop_front();
                if (got !== exp_o) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %p got %p", exp_o, got);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[i2c_master_transaction_engine_core] ERROR");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_write();
        test_reg_read();
        test_direct_read();
        test_nack();
        test_unit_extremes();
        test_random();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (bus_levels_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && bus_levels_q.size() == 0)
            $display("[i2c_master_transaction_engine_core] OK");
        else
            $display("[i2c_master_transaction_engine_core] ERROR");
        $finish;
    end
endmodule
